### rtl/lgrs_pkg.sv
// ----------------------------------------------------------------------------
// lgrs_pkg
// Types and constants shared by the random source controller and datapath.
// ----------------------------------------------------------------------------
package lgrs_pkg;

    localparam int SEED_W   = 27;
    localparam int CUT_W    = 30;
    localparam int SAMPLE_W = 31;
    localparam int ACC_W    = 31;
    localparam int T_W      = 32;
    localparam int Q_W      = 5;
    localparam int RECIP_W  = 14;
    localparam int PROD_W   = T_W + RECIP_W;
    localparam int STEP_W   = 4;

    localparam logic [T_W-1:0] LCG_MUL      = 32'd19;
    localparam logic [T_W-1:0] LCG_ADD      = 32'd656329;
    localparam logic [T_W-1:0] LCG_MOD      = 32'd100000001;
    localparam logic [T_W-1:0] NEW_SEED_OFS = 32'd54321;
    localparam logic [T_W-1:0] SUM_BIAS     = 32'd600000000;

    // floor(2**40 / LCG_MOD); the estimate is low by at most one.
    localparam logic [RECIP_W-1:0] RECIP       = 14'd10995;
    localparam int                 RECIP_SHIFT = 40;

    localparam logic [STEP_W-1:0] LAST_STEP = 4'd11;

    localparam logic [1:0] REQ_UNIFORM  = 2'd0;
    localparam logic [1:0] REQ_GAUSSIAN = 2'd1;
    localparam logic [1:0] REQ_NEW_SEED = 2'd2;
    localparam logic [1:0] REQ_LOAD     = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_QUO,
        ST_RED,
        ST_OFS,
        ST_SUM,
        ST_CHK,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        MODE_UNIFORM,
        MODE_GAUSSIAN,
        MODE_NEW_SEED
    } mode_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_CLEAR,
        ACC_ADD
    } acc_op_t;

    typedef enum logic [1:0] {
        DST_NONE,
        DST_CUR,
        DST_BASE
    } red_dst_t;

    typedef enum logic [1:0] {
        CAP_NONE,
        CAP_RED,
        CAP_GAUSS,
        CAP_ZERO
    } cap_t;

    typedef struct packed {
        logic     load_seed;
        logic     src_base;
        logic     t_load;
        logic     q_load;
        red_dst_t red_dst;
        logic     ofs_load;
        acc_op_t  acc_op;
        cap_t     cap;
    } dp_cmd_t;

    typedef struct packed {
        logic in_range;
    } dp_sts_t;

endpackage

### rtl/lgrs_datapath.sv
// ----------------------------------------------------------------------------
// lgrs_datapath
// Seed registers, generator step arithmetic, gaussian sum and cut check.
// ----------------------------------------------------------------------------
module lgrs_datapath
    import lgrs_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [CUT_W-1:0]           cfg_wr_data,
    input  logic [SEED_W-1:0]          seed_value,
    input  dp_cmd_t                    cmd,
    output dp_sts_t                    sts,
    output logic signed [SAMPLE_W-1:0] sample
);

    logic [SEED_W-1:0]          base_reg, base_next;
    logic [SEED_W-1:0]          cur_reg, cur_next;
    logic [CUT_W-1:0]           cut_reg;
    logic signed [T_W-1:0]      lo_reg, hi_reg;
    logic [T_W-1:0]             t_reg, t_next;
    logic [Q_W-1:0]             q_reg, q_next;
    logic [ACC_W-1:0]           acc_reg, acc_next;
    logic signed [SAMPLE_W-1:0] sample_reg, sample_next;

    logic [SEED_W-1:0]     src;
    logic [PROD_W-1:0]     prod;
    logic [T_W-1:0]        qm;
    logic [T_W-1:0]        rem;
    logic [T_W-1:0]        red;
    logic [SEED_W-1:0]     red_seed;
    logic [SEED_W:0]       ofs_sum;
    logic [SEED_W:0]       ofs_red;
    logic signed [T_W-1:0] acc_s;
    logic signed [T_W-1:0] gauss_val;

    always_comb begin
        src    = cmd.src_base ? base_reg : cur_reg;
        t_next = ({{(T_W-SEED_W){1'b0}}, src} * LCG_MUL) + LCG_ADD;

        prod   = PROD_W'(t_reg) * PROD_W'(RECIP);
        q_next = prod[RECIP_SHIFT +: Q_W];

        qm       = T_W'(q_reg) * LCG_MOD;
        rem      = t_reg - qm;
        red      = (rem >= LCG_MOD) ? (rem - LCG_MOD) : rem;
        red_seed = red[SEED_W-1:0];

        ofs_sum = {1'b0, base_reg} + NEW_SEED_OFS[SEED_W:0];
        ofs_red = (ofs_sum >= LCG_MOD[SEED_W:0]) ? (ofs_sum - LCG_MOD[SEED_W:0]) : ofs_sum;

        acc_s     = $signed({1'b0, acc_reg});
        gauss_val = acc_s - $signed(SUM_BIAS);

        base_next = base_reg;
        cur_next  = cur_reg;
        if (cmd.load_seed) begin
            base_next = seed_value;
            cur_next  = seed_value;
        end else if (cmd.ofs_load) begin
            cur_next = ofs_red[SEED_W-1:0];
        end else begin
            unique case (cmd.red_dst)
                DST_CUR:  cur_next  = red_seed;
                DST_BASE: base_next = red_seed;
                default:  ;
            endcase
        end

        unique case (cmd.acc_op)
            ACC_CLEAR: acc_next = '0;
            ACC_ADD:   acc_next = acc_reg + ACC_W'(cur_reg);
            default:   acc_next = acc_reg;
        endcase

        unique case (cmd.cap)
            CAP_RED:   sample_next = $signed({{(SAMPLE_W-SEED_W){1'b0}}, red_seed});
            CAP_GAUSS: sample_next = gauss_val[SAMPLE_W-1:0];
            CAP_ZERO:  sample_next = '0;
            default:   sample_next = sample_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= '0;
            cur_reg  <= '0;
            cut_reg  <= '0;
        end else begin
            base_reg <= base_next;
            cur_reg  <= cur_next;
            if (cfg_wr_en) begin
                cut_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg     <= $signed(SUM_BIAS) - $signed(T_W'(cut_reg));
        hi_reg     <= $signed(SUM_BIAS) + $signed(T_W'(cut_reg));
        acc_reg    <= acc_next;
        sample_reg <= sample_next;
        if (cmd.t_load) begin
            t_reg <= t_next;
        end
        if (cmd.q_load) begin
            q_reg <= q_next;
        end
    end

    assign sts.in_range = (acc_s >= lo_reg) && (acc_s <= hi_reg);
    assign sample       = sample_reg;

endmodule

### rtl/lgrs_ctrl.sv
// ----------------------------------------------------------------------------
// lgrs_ctrl
// Sequencer for generator steps, gaussian attempts and result hand-off.
// ----------------------------------------------------------------------------
module lgrs_ctrl
    import lgrs_pkg::*;
#(
    parameter int MAX_ATTEMPTS = 100
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    input  logic [1:0] in_req,
    output logic       in_ready,
    input  logic       out_free,
    output logic       push,
    output logic       res_status,
    output dp_cmd_t    cmd,
    input  dp_sts_t    sts
);

    localparam int ATT_W = $clog2(MAX_ATTEMPTS + 1);
    localparam logic [ATT_W-1:0] ATT_LAST = ATT_W'(MAX_ATTEMPTS - 1);

    state_t            state_reg, state_next;
    mode_t             mode_reg, mode_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [ATT_W-1:0]  att_reg, att_next;
    logic              extra_reg, extra_next;
    logic              status_reg, status_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            mode_reg   <= MODE_UNIFORM;
            step_reg   <= '0;
            att_reg    <= '0;
            extra_reg  <= 1'b0;
            status_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mode_reg   <= mode_next;
            step_reg   <= step_next;
            att_reg    <= att_next;
            extra_reg  <= extra_next;
            status_reg <= status_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        step_next   = step_reg;
        att_next    = att_reg;
        extra_next  = extra_reg;
        status_next = status_reg;
        in_ready    = 1'b0;
        push        = 1'b0;
        cmd         = '{load_seed: 1'b0, src_base: 1'b0, t_load: 1'b0, q_load: 1'b0,
                        red_dst: DST_NONE, ofs_load: 1'b0, acc_op: ACC_HOLD,
                        cap: CAP_NONE};

        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    status_next = 1'b0;
                    step_next   = '0;
                    att_next    = '0;
                    extra_next  = 1'b0;
                    unique case (in_req)
                        REQ_UNIFORM: begin
                            mode_next  = MODE_UNIFORM;
                            state_next = ST_MUL;
                        end
                        REQ_GAUSSIAN: begin
                            mode_next  = MODE_GAUSSIAN;
                            cmd.acc_op = ACC_CLEAR;
                            state_next = ST_MUL;
                        end
                        REQ_NEW_SEED: begin
                            mode_next  = MODE_NEW_SEED;
                            state_next = ST_MUL;
                        end
                        REQ_LOAD: begin
                            cmd.load_seed = 1'b1;
                            cmd.cap       = CAP_ZERO;
                            state_next    = ST_DONE;
                        end
                        default: ;
                    endcase
                end
            end
            ST_MUL: begin
                cmd.src_base = (mode_reg == MODE_NEW_SEED);
                cmd.t_load   = 1'b1;
                if (mode_reg == MODE_GAUSSIAN && step_reg != '0) begin
                    cmd.acc_op = ACC_ADD;
                end
                state_next = ST_QUO;
            end
            ST_QUO: begin
                cmd.q_load = 1'b1;
                state_next = ST_RED;
            end
            ST_RED: begin
                unique case (mode_reg)
                    MODE_UNIFORM: begin
                        cmd.red_dst = DST_CUR;
                        cmd.cap     = CAP_RED;
                        state_next  = ST_DONE;
                    end
                    MODE_NEW_SEED: begin
                        cmd.red_dst = DST_BASE;
                        state_next  = ST_OFS;
                    end
                    MODE_GAUSSIAN: begin
                        cmd.red_dst = DST_CUR;
                        if (step_reg == LAST_STEP) begin
                            step_next  = '0;
                            state_next = ST_SUM;
                        end else begin
                            step_next  = step_reg + 1'b1;
                            state_next = ST_MUL;
                        end
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_OFS: begin
                cmd.ofs_load = 1'b1;
                cmd.cap      = CAP_ZERO;
                state_next   = ST_DONE;
            end
            ST_SUM: begin
                cmd.acc_op = ACC_ADD;
                state_next = ST_CHK;
            end
            ST_CHK: begin
                if (extra_reg) begin
                    cmd.cap     = CAP_ZERO;
                    status_next = 1'b1;
                    state_next  = ST_DONE;
                end else if (sts.in_range) begin
                    cmd.cap    = CAP_GAUSS;
                    state_next = ST_DONE;
                end else begin
                    cmd.acc_op = ACC_CLEAR;
                    state_next = ST_MUL;
                    if (att_reg == ATT_LAST) begin
                        extra_next = 1'b1;
                    end else begin
                        att_next = att_reg + 1'b1;
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    push       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign res_status = status_reg;

endmodule

### rtl/lcg_gaussian_random_source_core.sv
// ----------------------------------------------------------------------------
// lcg_gaussian_random_source_core
// Uniform and gaussian random source on a linear congruential generator.
//
//   channel  direction  handshake        tdata               tuser
//   s_       in         tvalid/tready    [26:0] seed_value   [1:0] req_type
//   m_       out        tvalid/tready    [30:0] sample       [0] status
//   cfg_     in         wr_en            [29:0] cut_limit    -
//
// A generator step runs multiply, quotient estimate and reduction in
// turn, all on one shared step unit. A gaussian draw makes up to
// MAX_ATTEMPTS + 1 attempts.
// Reset is synchronous; seeds and the cut register clear to zero.
// A result waits in the output register while the next item is accepted;
// the sequencer stalls only when a second result is ready before the first
// is taken.
// ----------------------------------------------------------------------------
module lcg_gaussian_random_source_core
    import lgrs_pkg::*;
#(
    parameter int MAX_ATTEMPTS = 100
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [CUT_W-1:0] cfg_wr_data,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [31:0]      s_tdata,   // [26:0] seed_value
    input  logic [1:0]       s_tuser,   // [1:0] req_type
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [31:0]      m_tdata,   // [30:0] sample
    output logic             m_tuser    // [0] status
);

    dp_cmd_t                    cmd;
    dp_sts_t                    sts;
    logic                       push;
    logic                       res_status;
    logic                       out_free;
    logic signed [SAMPLE_W-1:0] dp_sample;

    logic        m_valid_reg;
    logic [31:0] m_data_reg;
    logic        m_user_reg;

    assign out_free = !m_valid_reg || m_tready;

    lgrs_ctrl #(
        .MAX_ATTEMPTS(MAX_ATTEMPTS)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_req     (s_tuser),
        .in_ready   (s_tready),
        .out_free   (out_free),
        .push       (push),
        .res_status (res_status),
        .cmd        (cmd),
        .sts        (sts)
    );

    lgrs_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .seed_value  (s_tdata[SEED_W-1:0]),
        .cmd         (cmd),
        .sts         (sts),
        .sample      (dp_sample)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (push) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            m_data_reg <= {1'b0, dp_sample};
            m_user_reg <= res_status;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule
